// ===== hw/rtl/iprmt_pkg.sv =====
// Package for the IPv4 range membership table.
// Holds the item kind codes, status codes, internal opcodes and the command word type.
// No dependencies.
package iprmt_pkg;

  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_LOOKUP   = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ORDER = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned EntryTotalW = 9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD,
    OP_BAD_ADD,
    OP_LOOKUP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] lookup_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
  } entry_t;

endpackage

// ===== hw/rtl/iprmt_in_if.sv =====
// Input channel of the range table: valid, ready and one input word.
// No dependencies.
interface iprmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [31:0] lookup_address;

  modport source (output valid, kind, range_low, range_high, lookup_address, input ready);
  modport sink   (input valid, kind, range_low, range_high, lookup_address, output ready);
endinterface

// ===== hw/rtl/iprmt_out_if.sv =====
// Result channel of the range table: valid, ready and one result word.
// No dependencies.
interface iprmt_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;
  logic [8:0] entry_total;

  modport source (output valid, hit, status, entry_total, input ready);
  modport sink   (input valid, hit, status, entry_total, output ready);
endinterface

// ===== hw/rtl/iprmt_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module iprmt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/iprmt_front.sv =====
// Front end of the range table: accepts input words, classifies them into
// commands and buffers them in a two-entry queue. Depends on iprmt_pkg, iprmt_in_if.
module iprmt_front import iprmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  iprmt_in_if.sink    in_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  cmd_t       q_mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.range_low      = in_i.range_low;
    cls.range_high     = in_i.range_high;
    cls.lookup_address = in_i.lookup_address;
    unique case (in_i.kind)
      KIND_CLEAR:  cls.op = OP_CLEAR;
      KIND_ADD:    cls.op = (in_i.range_low > in_i.range_high) ? OP_BAD_ADD : OP_ADD;
      KIND_LOOKUP: cls.op = OP_LOOKUP;
      default:     cls.op = OP_NONE;
    endcase
  end

  assign in_i.ready  = (fill_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rp_q];

  always_comb begin
    wp_d   = push ? ~wp_q : wp_q;
    rp_d   = pop ? ~rp_q : rp_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'd2)
    else $error("queue overfilled");
  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 || fill_q == 2'd2) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with fill");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fill_q == $past(fill_q) + 2'd1))
    else $error("push lost");
`endif

endmodule

// ===== hw/rtl/iprmt_back.sv =====
// Back end of the range table: executes clear, add and lookup commands on the
// range RAM and holds the result word. Depends on iprmt_pkg, iprmt_ram, iprmt_out_if.
module iprmt_back import iprmt_pkg::*; #(
  parameter int unsigned MaxRanges = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  iprmt_out_if.source out_o
);

  localparam int unsigned CW = $clog2(MaxRanges + 1);
  localparam int unsigned AW = $clog2(MaxRanges);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_SCAN_RD  = 10'b0000000010,
    ST_SCAN_CHK = 10'b0000000100,
    ST_DEC      = 10'b0000001000,
    ST_MV_RD    = 10'b0000010000,
    ST_MV_CHK   = 10'b0000100000,
    ST_FIN      = 10'b0001000000,
    ST_LK_RD    = 10'b0010000000,
    ST_LK_CHK   = 10'b0100000000,
    ST_OUT      = 10'b1000000000
  } state_e;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, rem_q, rem_d;
  logic [CW-1:0] blo_q, blo_d, bhi_q, bhi_d, mid_q, mid_d, mid;
  logic          cand_q, cand_d, ins_q, ins_d, pv_q, pv_d;
  entry_t        pend_q, pend_d;
  logic          hit_q, hit_d;
  logic [1:0]    status_q, status_d;
  logic [CW:0]   mid_sum;
  logic          last_i, new_covers, old_covers;
  entry_t        rd_e, wr_e, new_e;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   rdata;

  iprmt_ram #(.Width(64), .Depth(MaxRanges)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_e),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_e        = entry_t'(rdata);
  assign new_e       = '{start_addr: cmd_q.range_low, end_addr: cmd_q.range_high};
  assign mid_sum     = {1'b0, blo_q} + {1'b0, bhi_q};
  assign mid         = mid_sum[CW:1];
  assign last_i      = ((i_q + CW'(1)) == cnt_q);
  assign old_covers  = (rd_e.start_addr <= cmd_q.range_low) &&
                       (cmd_q.range_high <= rd_e.end_addr);
  assign new_covers  = (cmd_q.range_low <= rd_e.start_addr) &&
                       (rd_e.end_addr <= cmd_q.range_high);
  assign raddr       = (state_q == ST_LK_RD) ? mid[AW-1:0] : i_q[AW-1:0];
  assign cmd_ready_o = (state_q == ST_IDLE);

  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.hit         = hit_q;
  assign out_o.status      = status_q;
  assign out_o.entry_total = EntryTotalW'(cnt_q);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    rem_d    = rem_q;
    blo_d    = blo_q;
    bhi_d    = bhi_q;
    mid_d    = mid_q;
    cand_d   = cand_q;
    ins_d    = ins_q;
    pv_d     = pv_q;
    pend_d   = pend_q;
    hit_d    = hit_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = j_q[AW-1:0];
    wr_e     = new_e;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          hit_d    = 1'b0;
          status_d = STATUS_OK;
          i_d      = '0;
          rem_d    = '0;
          blo_d    = '0;
          bhi_d    = cnt_q;
          cand_d   = 1'b0;
          case (cmd_i.op)
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_OUT;
            end
            OP_BAD_ADD: begin
              status_d = STATUS_ORDER;
              state_d  = ST_OUT;
            end
            OP_ADD:    state_d = (cnt_q == '0) ? ST_DEC : ST_SCAN_RD;
            OP_LOOKUP: state_d = ST_LK_RD;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (old_covers) begin
          state_d = ST_OUT;
        end else begin
          rem_d   = rem_q + CW'(new_covers);
          i_d     = i_q + CW'(1);
          state_d = last_i ? ST_DEC : ST_SCAN_RD;
        end
      end
      ST_DEC: begin
        i_d   = '0;
        j_d   = '0;
        ins_d = 1'b0;
        pv_d  = 1'b0;
        if ((cnt_q - rem_q) >= CW'(MaxRanges)) begin
          status_d = STATUS_FULL;
          state_d  = ST_OUT;
        end else begin
          state_d = (cnt_q == '0) ? ST_FIN : ST_MV_RD;
        end
      end
      ST_MV_RD: state_d = ST_MV_CHK;
      ST_MV_CHK: begin
        if (!new_covers) begin
          we  = 1'b1;
          j_d = j_q + CW'(1);
          if (!ins_q && (rd_e.start_addr >= cmd_q.range_low)) begin
            wr_e   = new_e;
            ins_d  = 1'b1;
            pv_d   = 1'b1;
            pend_d = rd_e;
          end else if (pv_q) begin
            wr_e   = pend_q;
            pend_d = rd_e;
          end else begin
            wr_e = rd_e;
          end
        end
        i_d     = i_q + CW'(1);
        state_d = last_i ? ST_FIN : ST_MV_RD;
      end
      ST_FIN: begin
        we      = pv_q || !ins_q;
        wr_e    = pv_q ? pend_q : new_e;
        cnt_d   = j_q + CW'(1);
        state_d = ST_OUT;
      end
      ST_LK_RD: begin
        if (blo_q == bhi_q) begin
          hit_d   = cand_q;
          state_d = ST_OUT;
        end else begin
          mid_d   = mid;
          state_d = ST_LK_CHK;
        end
      end
      ST_LK_CHK: begin
        if (rd_e.start_addr <= cmd_q.lookup_address) begin
          blo_d  = mid_q + CW'(1);
          cand_d = (rd_e.end_addr >= cmd_q.lookup_address);
        end else begin
          bhi_d = mid_q;
        end
        state_d = ST_LK_RD;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    i_q      <= i_d;
    j_q      <= j_d;
    rem_q    <= rem_d;
    blo_q    <= blo_d;
    bhi_q    <= bhi_d;
    mid_q    <= mid_d;
    cand_q   <= cand_d;
    ins_q    <= ins_d;
    pv_q     <= pv_d;
    pend_q   <= pend_d;
    hit_q    <= hit_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxRanges))
    else $error("range count above capacity");
  a_miss_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != STATUS_OK) |-> !out_o.hit)
    else $error("hit reported with error status");
  a_write_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MV_CHK) |-> (j_q <= i_q))
    else $error("compaction write ahead of read");
  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (cnt_q == $past(j_q) + CW'(1)))
    else $error("count not updated after insert");
`endif

endmodule

// ===== hw/rtl/ip_range_membership_table_top.sv =====
// Lookup: a binary search, one RAM read per search step. Add: a scan and a compaction pass
// over the RAM; the scan ends early when a stored range already covers the new one.
// Throughput: one word at a time in the back end; the front queue holds two more words.
// Reset: asynchronous, active low; clears the count and control state, RAM is not cleared.
module ip_range_membership_table_top import iprmt_pkg::*; #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iprmt_in_if.sink     in_i,
  iprmt_out_if.source  out_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  iprmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  iprmt_back #(.MaxRanges(MAX_RANGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

// ===== tb/tb_ip_range_membership_table_top.sv =====
// Self-checking testbench for the IPv4 range membership table: drives clear, add and
// lookup words through the input channel and checks every result word against a predictor.
// Depends on iprmt_pkg, iprmt_in_if, iprmt_out_if and ip_range_membership_table_top.
`timescale 1ns / 100ps

module tb_ip_range_membership_table_top;
  import iprmt_pkg::*;

  localparam int unsigned TableDepth = 256;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
    logic [8:0] entry_total;
  } result_t;

  logic clk_i;
  logic rst_ni;

  iprmt_in_if  in_if ();
  iprmt_out_if out_if ();

  ip_range_membership_table_top #(
    .MAX_RANGES(TableDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [31:0] model_start[TableDepth];
  logic [31:0] model_end[TableDepth];
  int unsigned model_count;

  result_t     pending_results[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic result_t predict_result(logic [1:0] kind, logic [31:0] lo,
                                             logic [31:0] hi, logic [31:0] addr);
    result_t     res;
    int unsigned removed;
    int unsigned keep;
    int unsigned pos;
    bit          absorbed;
    res = '0;
    removed = 0;
    absorbed = 1'b0;
    if (kind == KIND_CLEAR) begin
      model_count = 0;
    end else if (kind == KIND_ADD) begin
      if (lo > hi) begin
        res.status = STATUS_ORDER;
      end else begin
        for (int i = 0; i < model_count; i++) begin
          if (model_start[i] <= lo && hi <= model_end[i]) absorbed = 1'b1;
          else if (lo <= model_start[i] && model_end[i] <= hi) removed++;
        end
        if (!absorbed) begin
          if (model_count - removed >= TableDepth) begin
            res.status = STATUS_FULL;
          end else begin
            keep = 0;
            for (int i = 0; i < model_count; i++) begin
              if (!(lo <= model_start[i] && model_end[i] <= hi)) begin
                model_start[keep] = model_start[i];
                model_end[keep] = model_end[i];
                keep++;
              end
            end
            pos = 0;
            while (pos < keep && model_start[pos] < lo) pos++;
            for (int i = keep; i > pos; i--) begin
              model_start[i] = model_start[i-1];
              model_end[i] = model_end[i-1];
            end
            model_start[pos] = lo;
            model_end[pos] = hi;
            model_count = keep + 1;
          end
        end
      end
    end else if (kind == KIND_LOOKUP) begin
      for (int i = 0; i < model_count; i++) begin
        if (model_start[i] <= addr && addr <= model_end[i]) res.hit = 1'b1;
      end
    end
    res.entry_total = model_count[8:0];
    return res;
  endfunction

  task automatic send_word(logic [1:0] kind, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.range_low <= lo;
    in_if.range_high <= hi;
    in_if.lookup_address <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_result(kind, lo, hi, addr));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      out_if.ready <= 1'b0;
      for (int n = 1; n < 300; n++) @(posedge clk_i);
      hold_req <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result word: hit %0d status %0d total %0d",
                   out_if.hit, out_if.status, out_if.entry_total);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_if.hit !== want.hit || out_if.status !== want.status ||
            out_if.entry_total !== want.entry_total) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected hit %0d status %0d total %0d,",
                     want.hit, want.status, want.entry_total,
                     " got hit %0d status %0d total %0d",
                     out_if.hit, out_if.status, out_if.entry_total);
          end
        end
      end
    end
  end

  function automatic logic [31:0] near_address(logic [31:0] window);
    if ($urandom_range(9) < 7) return window + $urandom_range(1023);
    return $urandom;
  endfunction

  task automatic test_directed();
    send_word(KIND_LOOKUP, 0, 0, 32'h0A00_0001);
    send_word(KIND_RESERVED, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_word(KIND_ADD, 32'h0000_0010, 32'h0000_000F, 0);
    send_word(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 0);
    send_word(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(KIND_LOOKUP, 0, 0, 32'h0000_0000);
    send_word(KIND_LOOKUP, 0, 0, 32'hFFFF_FFFF);
    send_word(KIND_LOOKUP, 0, 0, 32'h0000_0001);
    send_word(KIND_ADD, 32'h0A00_0000, 32'h0AFF_FFFF, 0);
    send_word(KIND_ADD, 32'h0A10_0000, 32'h0A10_00FF, 0);
    send_word(KIND_ADD, 32'hC0A8_0000, 32'hC0A8_00FF, 0);
    send_word(KIND_ADD, 32'hC0A8_0200, 32'hC0A8_02FF, 0);
    send_word(KIND_ADD, 32'hC0A8_0000, 32'hC0A8_FFFF, 0);
    send_word(KIND_LOOKUP, 0, 0, 32'h0AFF_FFFF);
    send_word(KIND_LOOKUP, 0, 0, 32'h0B00_0000);
    send_word(KIND_LOOKUP, 0, 0, 32'hC0A8_0150);
    send_word(KIND_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_word(KIND_LOOKUP, 0, 0, 32'h5555_AAAA);
    send_word(KIND_RESERVED, 0, 0, 0);
    send_word(KIND_CLEAR, 0, 0, 0);
    send_word(KIND_LOOKUP, 0, 0, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_table_full();
    send_word(KIND_CLEAR, 0, 0, 0);
    for (int i = TableDepth - 1; i >= 0; i--) begin
      send_word(KIND_ADD, i * 16, i * 16 + 3, 0);
    end
    send_word(KIND_ADD, 32'h8000_0000, 32'h8000_0001, 0);
    send_word(KIND_ADD, 32'h0000_0001, 32'h0000_0002, 0);
    send_word(KIND_LOOKUP, 0, 0, 32'h0000_0FF3);
    send_word(KIND_LOOKUP, 0, 0, 32'h0000_0FF4);
    send_word(KIND_ADD, 32'h0000_0000, 32'h0000_0013, 0);
    send_word(KIND_ADD, 32'h8000_0000, 32'h8000_0001, 0);
    send_word(KIND_ADD, 32'h9000_0000, 32'h9000_0001, 0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned words);
    logic [31:0] window;
    logic [31:0] lo;
    logic [32:0] hi_wide;
    int unsigned pick;
    window = 32'h0;
    for (int n = 0; n < words; n++) begin
      pick = $urandom_range(99);
      if (n % 60 == 0) begin
        case ($urandom_range(3))
          0: window = 32'h0000_0000;
          1: window = 32'hFFFF_FC00;
          default: window = $urandom;
        endcase
      end
      if (pick < 3) begin
        send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 6) begin
        send_word(KIND_RESERVED, $urandom, $urandom, $urandom);
      end else if (pick < 48) begin
        lo = near_address(window);
        hi_wide = {1'b0, lo} + $urandom_range(63);
        if (hi_wide[32]) hi_wide = 33'h0_FFFF_FFFF;
        if ($urandom_range(9) == 0) send_word(KIND_ADD, lo, $urandom, $urandom);
        else send_word(KIND_ADD, lo, hi_wide[31:0], $urandom);
      end else begin
        send_word(KIND_LOOKUP, $urandom, $urandom, near_address(window));
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    for (int n = 0; n < 10; n++) begin
      send_word(KIND_LOOKUP, 0, 0, $urandom);
      send_word(KIND_ADD, n * 256, n * 256 + 7, 0);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_req = 1'b0;
    mismatch_count = 0;
    model_count = 0;
    send_idle_pct = 13;
    recv_idle_pct = 63;
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_CLEAR;
    in_if.range_low <= '0;
    in_if.range_high <= '0;
    in_if.lookup_address <= '0;
    out_if.ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(180);
    test_backpressure();
    send_idle_pct = 63;
    recv_idle_pct = 13;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    test_random(180);

    repeat (1200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_ip_range_membership_table_top: PASS");
    end else begin
      $display("tb_ip_range_membership_table_top: FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_ip_range_membership_table_top: FAIL");
    $finish;
  end

endmodule
